/* hw/rtl/base64_stream_decoder_defines.svh */
// Assertion macros shared by the base64 decoder RTL
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define B64D_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define B64D_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/b64d_pkg.sv */
// Types, constants and character lookup for the base64 stream decoder
`default_nettype none

package b64d_pkg;

  localparam int unsigned CQ_DEPTH  = 4;
  localparam int unsigned RES_DEPTH = 2;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PAD     = 8'h3D;

  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  typedef enum logic [1:0] {
    SYM_DATA,
    SYM_PAD,
    SYM_BAD
  } sym_kind_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       run_end;
    logic       error;
  } out_item_t;

  typedef struct packed {
    sym_kind_t  kind;
    logic [5:0] sextet;
    logic       last;
  } cls_item_t;

  function automatic cls_item_t classify(input in_item_t item);
    cls_item_t c;
    logic [7:0] ch;
    ch       = item.in_char;
    c.last   = item.last;
    c.kind   = SYM_BAD;
    c.sextet = '0;
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
      c.kind   = SYM_DATA;
      c.sextet = 6'(ch - CH_UPPER_A);
    end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
      c.kind   = SYM_DATA;
      c.sextet = 6'(ch - CH_LOWER_A + 8'd26);
    end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
      c.kind   = SYM_DATA;
      c.sextet = 6'(ch - CH_DIGIT_0 + 8'd52);
    end else if (ch == CH_PLUS) begin
      c.kind   = SYM_DATA;
      c.sextet = SEXTET_PLUS;
    end else if (ch == CH_SLASH) begin
      c.kind   = SYM_DATA;
      c.sextet = SEXTET_SLASH;
    end else if (ch == CH_PAD) begin
      c.kind   = SYM_PAD;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/base64_stream_decoder.sv */
// Top level of the streaming base64 decoder
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------------------
//   input    | in_push / in_full  | in_data: in_char, last
//   result   | out_pop / out_empty| out_data: data_byte, data_valid, run_end,
//            |                    |           error
//
// One character per cycle sustained while in_full is low; the front stage looks
// up each character and the back stage merges one queued character per clock
// while the result queue has room. Results pass the front register and both
// queues. Reset (rst_n low at a clock edge) empties both queues and starts a
// new run. A stalled result side fills the result queue, then the command
// queue, then the front register, and only then raises in_full.
`default_nettype none

module base64_stream_decoder #(
  parameter int unsigned CQ_DEPTH  = b64d_pkg::CQ_DEPTH,
  parameter int unsigned RES_DEPTH = b64d_pkg::RES_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  input  wire b64d_pkg::in_item_t  in_data,
  output logic                     in_full,
  input  wire logic                out_pop,
  output b64d_pkg::out_item_t      out_data,
  output logic                     out_empty
);

  import b64d_pkg::*;

  logic      fr_push, cq_full, cq_empty, cq_pop;
  cls_item_t fr_data, cq_head;
  logic      res_push, res_full;
  out_item_t res_data;

  b64d_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .cq_push (fr_push),
    .cq_data (fr_data),
    .cq_full (cq_full)
  );

  b64d_fifo #(
    .DEPTH (CQ_DEPTH),
    .T     (cls_item_t)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fr_push),
    .wr_data (fr_data),
    .full    (cq_full),
    .pop     (cq_pop),
    .rd_data (cq_head),
    .empty   (cq_empty)
  );

  b64d_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_empty (cq_empty),
    .cq_data  (cq_head),
    .cq_pop   (cq_pop),
    .res_push (res_push),
    .res_data (res_data),
    .res_full (res_full)
  );

  b64d_fifo #(
    .DEPTH (RES_DEPTH),
    .T     (out_item_t)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_data),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (out_data),
    .empty   (out_empty)
  );

endmodule

`default_nettype wire

/* hw/rtl/b64d_fifo.sv */
// Small register FIFO used between decoder stages and at the output
`default_nettype none

`include "base64_stream_decoder_defines.svh"

module b64d_fifo #(
  parameter int unsigned DEPTH = b64d_pkg::CQ_DEPTH,
  parameter type T = logic
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire T     wr_data,
  output logic      full,
  input  wire logic pop,
  output T          rd_data,
  output logic      empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T              mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `B64D_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CW'(DEPTH), "fifo count beyond depth")
  `B64D_ASSERT_NXT(a_push_fills, do_push && !do_pop, !empty, "fifo empty after transfer in")
  `B64D_ASSERT_IMP(a_ptr_match, empty || full, wr_ptr_r == rd_ptr_r, "fifo pointers disagree")

endmodule

`default_nettype wire

/* hw/rtl/b64d_front.sv */
// Front stage: accept characters, classify them, hand them to the command queue
`default_nettype none

module b64d_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  input  wire b64d_pkg::in_item_t  in_data,
  output logic                     in_full,
  output logic                     cq_push,
  output b64d_pkg::cls_item_t      cq_data,
  input  wire logic                cq_full
);

  import b64d_pkg::*;

  logic      stage_vld_r, stage_vld_nxt;
  cls_item_t stage_r;
  logic      take;

  assign cq_push = stage_vld_r;
  assign cq_data = stage_r;
  assign in_full = stage_vld_r && cq_full;
  assign take    = in_push && !in_full;

  always_comb begin
    stage_vld_nxt = stage_vld_r;
    if (take) begin
      stage_vld_nxt = 1'b1;
    end else if (stage_vld_r && !cq_full) begin
      stage_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
    end else begin
      stage_vld_r <= stage_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage_r <= classify(in_data);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/b64d_back.sv */
// Back stage: group tracking, byte assembly and run error checking
`default_nettype none

`include "base64_stream_decoder_defines.svh"

module b64d_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cq_empty,
  input  wire b64d_pkg::cls_item_t  cq_data,
  output logic                      cq_pop,
  output logic                      res_push,
  output b64d_pkg::out_item_t       res_data,
  input  wire logic                 res_full
);

  import b64d_pkg::*;

  logic [1:0] group_pos_r, group_pos_nxt;
  logic [5:0] prev_r, prev_nxt;
  logic       pad_r, pad_nxt;
  logic       err_r, err_nxt;
  logic [5:0] val;
  logic [7:0] byte_val;
  logic       byte_vld;
  logic       take;

  assign take   = !cq_empty && !res_full;
  assign cq_pop = take;
  assign val    = (cq_data.kind == SYM_DATA) ? cq_data.sextet : '0;

  always_comb begin
    err_nxt  = err_r;
    pad_nxt  = pad_r;
    byte_val = '0;
    byte_vld = 1'b0;
    if (cq_data.kind == SYM_PAD) begin
      pad_nxt = 1'b1;
      case (group_pos_r)
        2'd2: begin
          if (pad_r || prev_r[3:0] != '0) err_nxt = 1'b1;
        end
        2'd3: begin
          if (!cq_data.last) err_nxt = 1'b1;
          if (!pad_r && prev_r[1:0] != '0) err_nxt = 1'b1;
        end
        default: begin
          err_nxt = 1'b1;
        end
      endcase
    end else begin
      if (cq_data.kind == SYM_BAD) err_nxt = 1'b1;
      if (pad_r) begin
        err_nxt = 1'b1;
      end else begin
        case (group_pos_r)
          2'd1: begin
            byte_val = {prev_r, val[5:4]};
            byte_vld = 1'b1;
          end
          2'd2: begin
            byte_val = {prev_r[3:0], val[5:2]};
            byte_vld = 1'b1;
          end
          2'd3: begin
            byte_val = {prev_r[1:0], val};
            byte_vld = 1'b1;
          end
          default: begin
            byte_vld = 1'b0;
          end
        endcase
      end
    end
    if (cq_data.last && group_pos_r != 2'd3) err_nxt = 1'b1;
  end

  always_comb begin
    res_push            = take && (byte_vld || cq_data.last);
    res_data.data_byte  = byte_val;
    res_data.data_valid = byte_vld;
    res_data.run_end    = cq_data.last;
    res_data.error      = cq_data.last && err_nxt;
    group_pos_nxt       = group_pos_r + 2'd1;
    prev_nxt            = val;
    if (cq_data.last) begin
      group_pos_nxt = '0;
      prev_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_pos_r <= '0;
      prev_r      <= '0;
      pad_r       <= 1'b0;
      err_r       <= 1'b0;
    end else if (take) begin
      group_pos_r <= group_pos_nxt;
      prev_r      <= prev_nxt;
      pad_r       <= pad_nxt && !cq_data.last;
      err_r       <= err_nxt && !cq_data.last;
    end
  end

  `B64D_ASSERT_NXT(a_run_clear, take && cq_data.last,
    group_pos_r == '0 && !pad_r && !err_r, "state not cleared after run end")
  `B64D_ASSERT_IMP(a_err_on_end, res_push && res_data.error, res_data.run_end,
    "error flagged off run end")
  `B64D_ASSERT_IMP(a_pad_pos, pad_r && (group_pos_r == 2'd1 || group_pos_r == 2'd2),
    err_r, "early padding without error")
  `B64D_ASSERT_IMP(a_no_drop, take && cq_data.kind == SYM_DATA && !pad_r &&
    group_pos_r != '0, res_push && res_data.data_valid, "decoded byte not transferred")

endmodule

`default_nettype wire
